// ----- sv/acae_pkg.sv -----
// Shared types and codes for the actuator command/ack endpoint.
// Used by the config register file, the endpoint core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package acae_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_ROLE         = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NODE_SUBJECT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEFAULT_OPEN = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_MS     = 2'd3;

    localparam logic [15:0] RETRY_MS_RESET = 16'd100;

    localparam logic ROLE_LOCAL  = 1'b0;
    localparam logic ROLE_REMOTE = 1'b1;

    localparam logic [2:0] OP_RESTART     = 3'd0;
    localparam logic [2:0] OP_SET         = 3'd1;
    localparam logic [2:0] OP_SET_DEFAULT = 3'd2;
    localparam logic [2:0] OP_RECEIVE     = 3'd3;
    localparam logic [2:0] OP_SERVICE_TX  = 3'd4;
    localparam logic [2:0] OP_REPORT      = 3'd5;

    localparam logic [1:0] CLS_CMD   = 2'd0;
    localparam logic [1:0] CLS_ACK   = 2'd1;
    localparam logic [1:0] CLS_STATE = 2'd2;

    typedef struct packed {
        logic        role;
        logic [7:0]  node_subject;
        logic        default_open;
        logic [15:0] retry_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  operation;
        logic        open_request;
        logic [1:0]  msg_class;
        logic [7:0]  msg_subject;
        logic [7:0]  msg_b0;
        logic [7:0]  msg_b1;
        logic [31:0] now_ms;
        logic        link_accepts;
    } t_item;

    typedef struct packed {
        logic       handled;
        logic       tx_valid;
        logic [1:0] tx_class;
        logic [7:0] tx_subject;
        logic [7:0] tx_b0;
        logic [7:0] tx_b1;
        logic       drive_level;
        logic       state_open;
        logic       energized;
        logic       confirmed;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/acae_cfg_regs.sv -----
// Configuration register file of the actuator endpoint.
// Depends on acae_pkg for the register indexes and the t_cfg type.
`timescale 1ns / 1ps
`default_nettype none

module acae_cfg_regs
    import acae_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role         <= ROLE_LOCAL;
            r_cfg.node_subject <= 8'd0;
            r_cfg.default_open <= 1'b0;
            r_cfg.retry_ms     <= RETRY_MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROLE:         r_cfg.role         <= i_cfg_data[0];
                CFG_NODE_SUBJECT: r_cfg.node_subject <= i_cfg_data[7:0];
                CFG_DEFAULT_OPEN: r_cfg.default_open <= i_cfg_data[0];
                CFG_RETRY_MS:     r_cfg.retry_ms     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/acae_core.sv -----
// Endpoint state and the single-pass update for one item.
// Depends on acae_pkg for codes, t_cfg, t_item and t_result.
`timescale 1ns / 1ps
`default_nettype none

module acae_core
    import acae_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_advance,
    input  wire t_item i_item,
    output t_result    o_result
);

    logic [7:0]  r_command_seq,   n_command_seq;
    logic        r_desired_open,  n_desired_open;
    logic        r_command_dirty, n_command_dirty;
    logic        r_awaiting_ack,  n_awaiting_ack;
    logic [31:0] r_last_sent,     n_last_sent;
    logic [7:0]  r_ack_seq,       n_ack_seq;
    logic        r_ack_pending,   n_ack_pending;
    logic        r_reported_open, n_reported_open;
    logic        r_energized,     n_energized;
    logic        r_confirmed,     n_confirmed;

    logic        set_en;
    logic        set_open;
    logic [31:0] elapsed;
    logic        resend;
    t_result     res;

    assign elapsed = i_item.now_ms - r_last_sent;
    assign resend  = r_awaiting_ack && (elapsed >= {16'd0, i_cfg.retry_ms});

    always_comb begin
        n_command_seq   = r_command_seq;
        n_desired_open  = r_desired_open;
        n_command_dirty = r_command_dirty;
        n_awaiting_ack  = r_awaiting_ack;
        n_last_sent     = r_last_sent;
        n_ack_seq       = r_ack_seq;
        n_ack_pending   = r_ack_pending;
        n_reported_open = r_reported_open;
        n_energized     = r_energized;
        n_confirmed     = r_confirmed;
        set_en          = 1'b0;
        set_open        = 1'b0;
        res             = '0;

        unique case (i_item.operation)
            OP_RESTART: begin
                n_command_seq   = 8'd0;
                n_desired_open  = i_cfg.default_open;
                n_command_dirty = 1'b0;
                n_awaiting_ack  = 1'b0;
                n_last_sent     = 32'd0;
                n_ack_seq       = 8'd0;
                n_ack_pending   = 1'b0;
                n_reported_open = i_cfg.default_open;
                n_energized     = 1'b0;
                n_confirmed     = (i_cfg.role == ROLE_LOCAL);
            end
            OP_SET: begin
                set_en   = 1'b1;
                set_open = i_item.open_request;
            end
            OP_SET_DEFAULT: begin
                set_en   = 1'b1;
                set_open = i_cfg.default_open;
            end
            OP_RECEIVE: begin
                if (i_item.msg_subject == i_cfg.node_subject) begin
                    if (i_cfg.role == ROLE_LOCAL) begin
                        if (i_item.msg_class == CLS_CMD) begin
                            set_en        = 1'b1;
                            set_open      = (i_item.msg_b1 == 8'd1);
                            n_ack_seq     = i_item.msg_b0;
                            n_ack_pending = 1'b1;
                            res.handled   = 1'b1;
                        end
                    end else if (i_item.msg_class == CLS_ACK) begin
                        if (i_item.msg_b0 == r_command_seq) begin
                            n_awaiting_ack = 1'b0;
                        end
                        res.handled = 1'b1;
                    end else if (i_item.msg_class == CLS_STATE) begin
                        n_reported_open = (i_item.msg_b0 == 8'd1);
                        n_energized     = (i_item.msg_b1 == 8'd1);
                        n_confirmed     = 1'b1;
                        res.handled     = 1'b1;
                    end
                end
            end
            OP_SERVICE_TX: begin
                if (i_cfg.role == ROLE_LOCAL) begin
                    if (r_ack_pending) begin
                        res.tx_valid   = 1'b1;
                        res.tx_class   = CLS_ACK;
                        res.tx_subject = i_cfg.node_subject;
                        res.tx_b0      = r_ack_seq;
                        if (i_item.link_accepts) begin
                            n_ack_pending = 1'b0;
                        end
                    end
                end else if (r_command_dirty || resend) begin
                    res.tx_valid   = 1'b1;
                    res.tx_class   = CLS_CMD;
                    res.tx_subject = i_cfg.node_subject;
                    res.tx_b0      = r_command_seq;
                    res.tx_b1      = {7'd0, r_desired_open};
                    if (i_item.link_accepts) begin
                        n_command_dirty = 1'b0;
                        n_last_sent     = i_item.now_ms;
                    end
                end
            end
            OP_REPORT: begin
                res.tx_valid   = 1'b1;
                res.tx_class   = CLS_STATE;
                res.tx_subject = i_cfg.node_subject;
                res.tx_b0      = {7'd0, r_reported_open};
                res.tx_b1      = {7'd0, r_energized};
            end
            default: ;
        endcase

        if (set_en) begin
            if (i_cfg.role == ROLE_LOCAL) begin
                n_energized     = (set_open != i_cfg.default_open);
                n_reported_open = set_open;
            end else if (r_command_dirty || (r_desired_open != set_open) || !r_awaiting_ack) begin
                n_desired_open  = set_open;
                n_command_seq   = r_command_seq + 8'd1;
                n_command_dirty = 1'b1;
                n_awaiting_ack  = 1'b1;
            end
        end

        res.drive_level = (i_cfg.role == ROLE_LOCAL) ? n_energized : 1'b0;
        res.state_open  = n_reported_open;
        res.energized   = n_energized;
        res.confirmed   = n_confirmed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_seq   <= 8'd0;
            r_desired_open  <= 1'b0;
            r_command_dirty <= 1'b0;
            r_awaiting_ack  <= 1'b0;
            r_last_sent     <= 32'd0;
            r_ack_seq       <= 8'd0;
            r_ack_pending   <= 1'b0;
            r_reported_open <= 1'b0;
            r_energized     <= 1'b0;
            r_confirmed     <= 1'b1;
        end else if (i_advance) begin
            r_command_seq   <= n_command_seq;
            r_desired_open  <= n_desired_open;
            r_command_dirty <= n_command_dirty;
            r_awaiting_ack  <= n_awaiting_ack;
            r_last_sent     <= n_last_sent;
            r_ack_seq       <= n_ack_seq;
            r_ack_pending   <= n_ack_pending;
            r_reported_open <= n_reported_open;
            r_energized     <= n_energized;
            r_confirmed     <= n_confirmed;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ----- sv/actuator_command_ack_endpoint_unit.sv -----
// Actuator command/ack endpoint: input register, endpoint core, result register.
// The input register feeds the core; the result register holds its result and offers it.
// Throughput: one item per cycle; a stall holds the result and, when full, the input register.
// Reset (synchronous, active low) empties both registers and loads the rest state.
// Depends on acae_pkg, acae_cfg_regs and acae_core.
`timescale 1ns / 1ps
`default_nettype none

module actuator_command_ack_endpoint_unit
    import acae_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire logic [2:0]          i_operation,
    input  wire logic                i_open_request,
    input  wire logic [1:0]          i_msg_class,
    input  wire logic [7:0]          i_msg_subject,
    input  wire logic [7:0]          i_msg_b0,
    input  wire logic [7:0]          i_msg_b1,
    input  wire logic [31:0]         i_now_ms,
    input  wire logic                i_link_accepts,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      logic                o_handled,
    output      logic                o_tx_valid,
    output      logic [1:0]          o_tx_class,
    output      logic [7:0]          o_tx_subject,
    output      logic [7:0]          o_tx_b0,
    output      logic [7:0]          o_tx_b1,
    output      logic                o_drive_level,
    output      logic                o_state_open,
    output      logic                o_energized,
    output      logic                o_confirmed
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    t_result core_res;
    logic    advance;
    logic    in_xfer;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    acae_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    acae_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.operation    <= i_operation;
            r_item.open_request <= i_open_request;
            r_item.msg_class    <= i_msg_class;
            r_item.msg_subject  <= i_msg_subject;
            r_item.msg_b0       <= i_msg_b0;
            r_item.msg_b1       <= i_msg_b1;
            r_item.now_ms       <= i_now_ms;
            r_item.link_accepts <= i_link_accepts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_handled     = r_res.handled;
    assign o_tx_valid    = r_res.tx_valid;
    assign o_tx_class    = r_res.tx_class;
    assign o_tx_subject  = r_res.tx_subject;
    assign o_tx_b0       = r_res.tx_b0;
    assign o_tx_b1       = r_res.tx_b1;
    assign o_drive_level = r_res.drive_level;
    assign o_state_open  = r_res.state_open;
    assign o_energized   = r_res.energized;
    assign o_confirmed   = r_res.confirmed;

endmodule

`default_nettype wire

// ----- sv/acae_checker.sv -----
// Port-level checks for the actuator endpoint, bound to the top level.
// Depends on acae_pkg for the message class codes.
`timescale 1ns / 1ps
`default_nettype none

module acae_checker
    import acae_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic                o_handled,
    input wire logic                o_tx_valid,
    input wire logic [1:0]          o_tx_class,
    input wire logic [7:0]          o_tx_subject,
    input wire logic [7:0]          o_tx_b0,
    input wire logic [7:0]          o_tx_b1,
    input wire logic                o_drive_level,
    input wire logic                o_energized
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_b0)
            && $stable(o_tx_class) && $stable(o_handled))
        else $error("stalled result changed");

    a_idle_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> o_tx_class == CLS_CMD && o_tx_subject == 8'd0
            && o_tx_b0 == 8'd0 && o_tx_b1 == 8'd0)
        else $error("tx fields set without tx_valid");

    a_handled_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_handled |-> !o_tx_valid)
        else $error("receive result offers a message");

    a_drive_energized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_level |-> o_energized)
        else $error("drive level without energized");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind actuator_command_ack_endpoint_unit acae_checker u_acae_checker (.*);

`default_nettype wire
